>>> src/bcpe_pkg.sv
// Shared types and constants for the Bezier curve point evaluator.
package bcpe_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int COORD_W        = 16;
  localparam int T_W            = 17;
  localparam int PCNT_W         = 4;
  localparam int PROD_W         = 35;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [T_W-1:0]    T_ONE     = 17'h10000;
  localparam logic [PROD_W-1:0] T_HALF    = 35'h8000;
  localparam logic [PCNT_W-1:0] PCNT_RST  = 4'd4;

  localparam logic [0:0] REG_POINT_COUNT = 1'b0;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef struct packed {
    logic               operation;
    logic [2:0]         point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [16:0]        param_t;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] curve_x;
    logic signed [15:0] curve_y;
  } out_item_t;

endpackage

>>> src/bcpe_lerp_cell.sv
// One de Casteljau level: multiply stage then round-and-add stage, all lanes in parallel.
module bcpe_lerp_cell import bcpe_pkg::*; #(
  parameter int MaxPoints = MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic [MaxPoints-1:0][COORD_W-1:0]    up_x,
  input  logic [MaxPoints-1:0][COORD_W-1:0]    up_y,
  input  logic [T_W-1:0]                       up_t,
  input  logic [$clog2(MaxPoints)-1:0]         up_rem,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic [MaxPoints-1:0][COORD_W-1:0]    dn_x,
  output logic [MaxPoints-1:0][COORD_W-1:0]    dn_y,
  output logic [T_W-1:0]                       dn_t,
  output logic [$clog2(MaxPoints)-1:0]         dn_rem
);

  localparam int LW = $clog2(MaxPoints);

  logic                              va_r;
  logic                              vb_r;
  logic                              rdy_a;
  logic                              rdy_b;
  logic                              active;
  logic [MaxPoints-1:0][COORD_W-1:0] ax_r;
  logic [MaxPoints-1:0][COORD_W-1:0] ay_r;
  logic signed [PROD_W-1:0]          px_nxt [MaxPoints];
  logic signed [PROD_W-1:0]          py_nxt [MaxPoints];
  logic signed [PROD_W-1:0]          px_r   [MaxPoints];
  logic signed [PROD_W-1:0]          py_r   [MaxPoints];
  logic [MaxPoints-1:0][COORD_W-1:0] bx_nxt;
  logic [MaxPoints-1:0][COORD_W-1:0] by_nxt;
  logic [MaxPoints-1:0][COORD_W-1:0] bx_r;
  logic [MaxPoints-1:0][COORD_W-1:0] by_r;
  logic [T_W-1:0]                    ta_r;
  logic [T_W-1:0]                    tb_r;
  logic [LW-1:0]                     rema_nxt;
  logic [LW-1:0]                     rema_r;
  logic [LW-1:0]                     remb_r;
  logic signed [T_W:0]               tt;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;
  assign active   = (up_rem != '0);
  assign rema_nxt = active ? up_rem - LW'(1) : '0;
  assign tt       = $signed({1'b0, up_t});

  for (genvar i = 0; i < MaxPoints; i++) begin : g_lane
    logic signed [COORD_W:0]  dx;
    logic signed [COORD_W:0]  dy;
    logic signed [PROD_W-1:0] sx;
    logic signed [PROD_W-1:0] sy;
    if (i < MaxPoints - 1) begin : g_pair
      assign dx = $signed({up_x[i+1][COORD_W-1], up_x[i+1]})
                - $signed({up_x[i][COORD_W-1], up_x[i]});
      assign dy = $signed({up_y[i+1][COORD_W-1], up_y[i+1]})
                - $signed({up_y[i][COORD_W-1], up_y[i]});
    end else begin : g_tail
      assign dx = '0;
      assign dy = '0;
    end
    assign px_nxt[i] = active ? PROD_W'(dx) * PROD_W'(tt) : '0;
    assign py_nxt[i] = active ? PROD_W'(dy) * PROD_W'(tt) : '0;
    assign sx        = px_r[i] + $signed(T_HALF);
    assign sy        = py_r[i] + $signed(T_HALF);
    assign bx_nxt[i] = ax_r[i] + sx[31:16];
    assign by_nxt[i] = ay_r[i] + sy[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_r <= up_valid;
      end
      if (rdy_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) begin
      ax_r   <= up_x;
      ay_r   <= up_y;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      ta_r   <= up_t;
      rema_r <= rema_nxt;
    end
    if (rdy_b && va_r) begin
      bx_r   <= bx_nxt;
      by_r   <= by_nxt;
      tb_r   <= ta_r;
      remb_r <= rema_r;
    end
  end

  assign dn_valid = vb_r;
  assign dn_x     = bx_r;
  assign dn_y     = by_r;
  assign dn_t     = tb_r;
  assign dn_rem   = remb_r;

endmodule

>>> src/bezier_curve_point_eval.sv
// Top level: control point table, entry stage and chain of de Casteljau level cells.
//
//   channel | ports                          | beat
//   --------+--------------------------------+-------------------------------------
//   in      | in_valid, in_ready, in_data    | load point or evaluate at param_t
//   out     | out_valid, out_ready, out_data | one curve point per evaluate
//   cfg     | cfg_psel .. cfg_pready         | point_count at byte address 0
//
// One beat per cycle in while in_ready is high; an evaluate beat passes the entry register,
// then a multiply stage and an add stage in each of the MaxPoints-1 level cells.
// A load takes effect at its accept edge and yields no out beat.
// Reset clears all valid flags and sets point_count to 4; the table is undefined until loaded.
// A stalled out beat backs up the chain stage by stage; in_ready drops only once full.
module bezier_curve_point_eval import bcpe_pkg::*; #(
  parameter int MaxPoints = MAX_POINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int LW = $clog2(MaxPoints);
  localparam int IW = $clog2(MaxPoints);
  localparam int NW = $clog2(MaxPoints + 1);

  logic [PCNT_W-1:0]                 pcnt_r;
  logic [COORD_W-1:0]                xtab_r [MaxPoints];
  logic [COORD_W-1:0]                ytab_r [MaxPoints];
  logic                              in_acc;
  logic [NW-1:0]                     n_eval;
  logic [LW-1:0]                     levels;
  logic [T_W-1:0]                    t_sat;

  logic                              chain_v   [MaxPoints];
  logic                              chain_rdy [MaxPoints];
  logic [MaxPoints-1:0][COORD_W-1:0] chain_x   [MaxPoints];
  logic [MaxPoints-1:0][COORD_W-1:0] chain_y   [MaxPoints];
  logic [T_W-1:0]                    chain_t   [MaxPoints];
  logic [LW-1:0]                     chain_rem [MaxPoints];

  logic                              entry_v_r;
  logic [MaxPoints-1:0][COORD_W-1:0] entry_x_r;
  logic [MaxPoints-1:0][COORD_W-1:0] entry_y_r;
  logic [T_W-1:0]                    entry_t_r;
  logic [LW-1:0]                     entry_rem_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= PCNT_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_POINT_COUNT) begin
      pcnt_r <= cfg_pwdata[PCNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_POINT_COUNT) begin
      cfg_prdata = CFG_DATA_W'(pcnt_r);
    end
  end

  assign in_ready = !entry_v_r || chain_rdy[0];
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == OP_LOAD && int'(in_data.point_index) < MaxPoints) begin
      xtab_r[IW'(in_data.point_index)] <= in_data.point_x;
      ytab_r[IW'(in_data.point_index)] <= in_data.point_y;
    end
  end

  always_comb begin
    if (pcnt_r == '0) begin
      n_eval = NW'(1);
    end else if (int'(pcnt_r) > MaxPoints) begin
      n_eval = NW'(MaxPoints);
    end else begin
      n_eval = NW'(pcnt_r);
    end
  end

  assign levels = LW'(n_eval - NW'(1));
  assign t_sat  = (in_data.param_t > T_ONE) ? T_ONE : in_data.param_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_v_r <= 1'b0;
    end else if (in_ready) begin
      entry_v_r <= in_valid && in_data.operation == OP_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.operation == OP_EVAL) begin
      for (int i = 0; i < MaxPoints; i++) begin
        entry_x_r[i] <= xtab_r[i];
        entry_y_r[i] <= ytab_r[i];
      end
      entry_t_r   <= t_sat;
      entry_rem_r <= levels;
    end
  end

  assign chain_v[0]   = entry_v_r;
  assign chain_x[0]   = entry_x_r;
  assign chain_y[0]   = entry_y_r;
  assign chain_t[0]   = entry_t_r;
  assign chain_rem[0] = entry_rem_r;

  for (genvar k = 0; k < MaxPoints - 1; k++) begin : g_cell
    bcpe_lerp_cell #(
      .MaxPoints (MaxPoints)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_v[k]),
      .up_ready (chain_rdy[k]),
      .up_x     (chain_x[k]),
      .up_y     (chain_y[k]),
      .up_t     (chain_t[k]),
      .up_rem   (chain_rem[k]),
      .dn_valid (chain_v[k+1]),
      .dn_ready (chain_rdy[k+1]),
      .dn_x     (chain_x[k+1]),
      .dn_y     (chain_y[k+1]),
      .dn_t     (chain_t[k+1]),
      .dn_rem   (chain_rem[k+1])
    );
  end

  assign chain_rdy[MaxPoints-1] = out_ready;
  assign out_valid              = chain_v[MaxPoints-1];
  assign out_data.curve_x       = chain_x[MaxPoints-1][0];
  assign out_data.curve_y       = chain_y[MaxPoints-1][0];

endmodule

>>> src/bcpe_checker.sv
// Port-level checks for the Bezier curve point evaluator, bound to the top level.
module bcpe_checker import bcpe_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_item_t             out_data,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low with a free output");

  a_pcnt_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
    cfg_paddr[2] == REG_POINT_COUNT ##1 cfg_paddr[2] == REG_POINT_COUNT
    |-> cfg_prdata[PCNT_W-1:0] == $past(cfg_pwdata[PCNT_W-1:0]))
    else $error("point_count readback mismatch");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("in beat dropped or changed while stalled");

endmodule

bind bezier_curve_point_eval bcpe_checker u_bcpe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_data     (in_data),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_data    (out_data),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);

>>> sim/testbench.sv
// Self-checking testbench for the Bezier curve point evaluator with its own curve predictor.
module testbench;
  import bcpe_pkg::*;

  localparam int LATENCY       = 2 * MAX_POINTS_DEF - 1;
  localparam int SETTLE_CYCLES = LATENCY + 6;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BEATS   = 190;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  in_item_t              in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  bezier_curve_point_eval u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  in_item_t           pending_beats[$];
  out_item_t          curve_points_due[$];
  logic signed [15:0] ctrl_x[MAX_POINTS_DEF];
  logic signed [15:0] ctrl_y[MAX_POINTS_DEF];
  logic [PCNT_W-1:0]  point_count_now = PCNT_RST;

  int  cycle_count     = 0;
  int  mismatch_count  = 0;
  int  loads_seen      = 0;
  int  evals_seen      = 0;
  int  results_checked = 0;
  int  gap_left        = 0;
  int  burst_left      = 0;
  int  rx_run          = 0;
  bit  rx_level        = 1'b1;
  bit  beat_taken      = 1'b0;
  bit  sender_steady   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [15:0] blend_q16(logic signed [15:0] a, logic signed [15:0] b,
                                                   longint t);
    longint d;
    longint p;
    d = longint'(b) - longint'(a);
    p = t * d + 32768;
    return 16'(longint'(a) + (p >>> 16));
  endfunction

  function automatic out_item_t casteljau_point(logic [T_W-1:0] t_raw);
    logic signed [15:0] wx[MAX_POINTS_DEF];
    logic signed [15:0] wy[MAX_POINTS_DEF];
    int                 n;
    longint             t;
    out_item_t          r;
    n = int'(point_count_now);
    if (n < 1) n = 1;
    if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
    t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
    for (int i = 0; i < n; i++) begin
      wx[i] = ctrl_x[i];
      wy[i] = ctrl_y[i];
    end
    for (int lvl = n; lvl > 1; lvl--) begin
      for (int i = 0; i + 1 < lvl; i++) begin
        wx[i] = blend_q16(wx[i], wx[i + 1], t);
        wy[i] = blend_q16(wy[i], wy[i + 1], t);
      end
    end
    r.curve_x = wx[0];
    r.curve_y = wy[0];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0d] mismatch: %s", cycle_count, msg);
  endtask

  task automatic queue_beat(input in_item_t b);
    pending_beats = {pending_beats, b};
  endtask

  function automatic in_item_t load_beat(logic [2:0] slot, logic signed [15:0] x,
                                         logic signed [15:0] y);
    in_item_t b;
    b.operation   = OP_LOAD;
    b.point_index = slot;
    b.point_x     = x;
    b.point_y     = y;
    b.param_t     = T_W'($urandom);
    return b;
  endfunction

  function automatic in_item_t eval_beat(logic [T_W-1:0] t);
    in_item_t b;
    b.operation   = OP_EVAL;
    b.point_index = 3'($urandom);
    b.point_x     = 16'($urandom);
    b.point_y     = 16'($urandom);
    b.param_t     = t;
    return b;
  endfunction

  function automatic logic signed [15:0] random_coord();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [T_W-1:0] random_param();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return T_ONE;
      2:       return T_W'($urandom_range(65537, 131071));
      3:       return T_W'($urandom_range(0, 15));
      4:       return T_W'(65536 - $urandom_range(1, 16));
      default: return T_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic queue_random_beats(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        queue_beat(load_beat(3'($urandom), random_coord(), random_coord()));
      else
        queue_beat(eval_beat(random_param()));
    end
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid) @(posedge clk);
    while (curve_points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_transfer(input logic write, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {REG_POINT_COUNT, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (write) begin
      point_count_now = data[PCNT_W-1:0];
    end else if (cfg_prdata[PCNT_W-1:0] !== point_count_now) begin
      flag_error($sformatf("point_count read %0d, want %0d", cfg_prdata[PCNT_W-1:0],
                           point_count_now));
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_point_count(input logic [PCNT_W-1:0] value);
    wait_idle();
    cfg_transfer(1'b1, CFG_DATA_W'(value));
    cfg_transfer(1'b0, '0);
  endtask

  always @(negedge clk) begin : feed_driver
    logic     next_valid;
    in_item_t next_item;
    next_valid = in_valid;
    next_item  = in_data;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_valid || beat_taken) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_beats.size() > 0) begin
        next_item  = pending_beats.pop_front();
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    beat_taken = 1'b0;
    in_valid <= next_valid;
    in_data  <= next_item;
  end

  always @(negedge clk) begin : rx_stall
    if (rx_run == 0) begin
      case ((cycle_count / 400) % 3)
        0: begin
          rx_level = 1'b1;
          rx_run   = 32;
        end
        1: begin
          rx_level = ($urandom_range(0, 3) != 0);
          rx_run   = $urandom_range(1, 3);
        end
        default: begin
          rx_level = !rx_level;
          rx_run   = rx_level ? $urandom_range(1, 8) : $urandom_range(1, 24);
        end
      endcase
    end
    rx_run--;
    out_ready <= rst_n && rx_level;
  end

  always @(posedge clk) begin : monitor
    in_item_t  b;
    out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        b          = in_data;
        beat_taken = 1'b1;
        if (op_e'(b.operation) == OP_LOAD) begin
          ctrl_x[b.point_index] = b.point_x;
          ctrl_y[b.point_index] = b.point_y;
          loads_seen++;
        end else begin
          curve_points_due = {curve_points_due, casteljau_point(b.param_t)};
          evals_seen++;
        end
      end
      if (out_valid && out_ready) begin
        if (curve_points_due.size() == 0) begin
          flag_error($sformatf("beat x=%0d y=%0d with nothing pending", out_data.curve_x,
                               out_data.curve_y));
        end else begin
          want = curve_points_due.pop_front();
          results_checked++;
          if (out_data.curve_x !== want.curve_x || out_data.curve_y !== want.curve_y)
            flag_error($sformatf("curve x=%0d y=%0d, want x=%0d y=%0d", out_data.curve_x,
                                 out_data.curve_y, want.curve_x, want.curve_y));
        end
      end
    end
  end

  initial begin : stimulus
    logic [PCNT_W-1:0] count;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    cfg_transfer(1'b0, '0);

    queue_beat(load_beat(3'd0, 16'sh8000, 16'sh7fff));
    queue_beat(load_beat(3'd1, 16'sh7fff, 16'sh8000));
    queue_beat(load_beat(3'd2, 16'sh0000, -16'sd1));
    queue_beat(load_beat(3'd3, -16'sd1, 16'sh0000));
    queue_beat(load_beat(3'd4, 16'sh7fff, 16'sh7fff));
    queue_beat(load_beat(3'd5, 16'sh8000, 16'sh8000));
    queue_beat(load_beat(3'd6, 16'sd12345, -16'sd2222));
    queue_beat(load_beat(3'd7, -16'sd4000, 16'sd777));
    queue_beat(eval_beat(17'd0));
    queue_beat(eval_beat(T_ONE));
    queue_beat(eval_beat(17'd32768));
    queue_beat(eval_beat(17'd1));
    queue_beat(eval_beat(17'd65535));
    queue_beat(eval_beat(17'h1ffff));
    queue_beat(eval_beat(17'd65537));

    set_point_count(4'd8);
    queue_beat(eval_beat(17'd32768));
    queue_beat(eval_beat(17'd0));
    queue_beat(eval_beat(17'h1ffff));
    set_point_count(4'd1);
    queue_beat(eval_beat(random_param()));
    set_point_count(4'd0);
    queue_beat(eval_beat(17'd40000));
    queue_beat(eval_beat(T_ONE));
    set_point_count(4'd15);
    queue_beat(eval_beat(17'd12345));
    queue_beat(eval_beat(T_ONE));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) count = 4'd8;
      else if (ph == 1) count = 4'd1;
      else count = PCNT_W'($urandom_range(1, 8));
      set_point_count(count);
      sender_steady = (ph == 2);
      if (ph == 3) begin
        queue_random_beats(PHASE_BEATS / 2);
        wait_idle();
        queue_random_beats(PHASE_BEATS - PHASE_BEATS / 2);
      end else begin
        queue_random_beats(PHASE_BEATS);
      end
    end
    wait_idle();

    $display("Ran %0d loads and %0d evaluates over point counts 0..15, %0d curve points checked,",
             loads_seen, evals_seen, results_checked);
    $display("with sender bursts and gaps, receiver stalls and %0d mismatches.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
